// ----- hw/rtl/tfn_pkg.sv -----
// Shared types and constants for the triangle face normal pipeline.
// No dependencies; imported by the core, the square root and the divider.
package tfn_pkg;

  // Corner count of a face that gets a normal
  localparam logic [7:0] TRI_CORNERS = 8'd3;

  // Scaled component, sum of squares, root and quotient widths
  localparam int COMP_W  = 32;
  localparam int SUM_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int FRAC_W  = 14;
  localparam int Q_W     = 15;
  localparam int NUM_W   = COMP_W + FRAC_W + 1;

  typedef logic [Q_W-1:0] tfn_q_t;

  // Per-request status that rides along with the data
  typedef struct packed {
    logic skip;
    logic degen;
  } tfn_flags_t;

  // Scaled component magnitudes, their signs and status
  typedef struct packed {
    logic [2:0][COMP_W-1:0] mag;
    logic [2:0]             neg;
    tfn_flags_t             flags;
  } tfn_side_t;

endpackage

// ----- hw/rtl/tfn_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on tfn_pkg; carries a tfn_side_t alongside each request.
module tfn_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [63:0]         in_sum,
  input  tfn_pkg::tfn_side_t  in_side,
  output logic                out_valid,
  output logic [31:0]         out_root,
  output tfn_pkg::tfn_side_t  out_side
);
  import tfn_pkg::*;

  localparam int STEPS = ROOT_W;

  logic                valid_r [0:STEPS];
  logic [SUM_W-1:0]    sum_r   [0:STEPS];
  logic [ROOT_W:0]     rem_r   [0:STEPS];
  logic [ROOT_W-1:0]   root_r  [0:STEPS];
  tfn_side_t           side_r  [0:STEPS];

  logic [ROOT_W:0]     rem_nxt  [0:STEPS-1];
  logic [ROOT_W-1:0]   root_nxt [0:STEPS-1];

  // Capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sum_r[0]  <= in_sum;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    side_r[0] <= in_side;
  end

  // One root bit per stage: bring down two radicand bits, try subtracting
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic              ge;

    always_comb begin
      rem_sh = {rem_r[k], sum_r[k][SUM_W-1-2*k -: 2]};
      trial  = (ROOT_W+3)'({root_r[k], 2'b01});
      ge     = (rem_sh >= trial);
      rem_nxt[k]  = ge ? (ROOT_W+1)'(rem_sh - trial) : (ROOT_W+1)'(rem_sh);
      root_nxt[k] = {root_r[k][ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k+1] <= 1'b0;
      end else begin
        valid_r[k+1] <= valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      sum_r[k+1]  <= sum_r[k];
      rem_r[k+1]  <= rem_nxt[k];
      root_r[k+1] <= root_nxt[k];
      side_r[k+1] <= side_r[k];
    end
  end

  assign out_valid = valid_r[STEPS];
  assign out_root  = root_r[STEPS];
  assign out_side  = side_r[STEPS];

endmodule

// ----- hw/rtl/tfn_div.sv -----
// Pipelined restoring divider: round(mag * 2^14 / root) for three components.
// Depends on tfn_pkg; one quotient bit per stage, all three lanes in step.
module tfn_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [31:0]           in_root,
  input  tfn_pkg::tfn_side_t    in_side,
  output logic                  out_valid,
  output tfn_pkg::tfn_q_t [2:0] out_q,
  output tfn_pkg::tfn_side_t    out_side
);
  import tfn_pkg::*;

  logic              valid_r [0:Q_W];
  logic [ROOT_W-1:0] root_r  [0:Q_W];
  logic [NUM_W-1:0]  rem_r   [0:Q_W][3];
  tfn_q_t            q_r     [0:Q_W][3];
  tfn_side_t         side_r  [0:Q_W];

  logic [NUM_W-1:0]  num_nxt [3];

  // Form the rounded numerator mag * 2^14 + root / 2
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num_nxt[c] = NUM_W'({in_side.mag[c], FRAC_W'(0)}) + NUM_W'(in_root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    root_r[0] <= in_root;
    side_r[0] <= in_side;
    for (int c = 0; c < 3; c++) begin
      rem_r[0][c] <= num_nxt[c];
      q_r[0][c]   <= '0;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int J = Q_W - 1 - k;
    logic [NUM_W-1:0] dv;
    logic [NUM_W-1:0] rem_nxt [3];
    tfn_q_t           q_nxt   [3];

    always_comb begin
      dv = NUM_W'(root_r[k]) << J;
      for (int c = 0; c < 3; c++) begin
        if (rem_r[k][c] >= dv) begin
          rem_nxt[c] = rem_r[k][c] - dv;
          q_nxt[c]   = {q_r[k][c][Q_W-2:0], 1'b1};
        end else begin
          rem_nxt[c] = rem_r[k][c];
          q_nxt[c]   = {q_r[k][c][Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k+1] <= 1'b0;
      end else begin
        valid_r[k+1] <= valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      root_r[k+1] <= root_r[k];
      side_r[k+1] <= side_r[k];
      for (int c = 0; c < 3; c++) begin
        rem_r[k+1][c] <= rem_nxt[c];
        q_r[k+1][c]   <= q_nxt[c];
      end
    end
  end

  assign out_valid = valid_r[Q_W];
  assign out_side  = side_r[Q_W];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      out_q[c] = q_r[Q_W][c];
    end
  end

endmodule

// ----- hw/rtl/triangle_face_normal_core.sv -----
// Triangle face normal core: edges, cross product, normalize, unit scale.
// Throughput: one face per cycle; busy stays low, the pipeline never stalls.
// Latency is set mostly by the 32-step root and 15-step divider pipelines.
// Reset (rst_n low, synchronous) clears every valid bit; data needs no reset.
// Depends on tfn_pkg, tfn_isqrt and tfn_div.
module triangle_face_normal_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         in_face_size,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic signed [31:0] in_c_x,
  input  logic signed [31:0] in_c_y,
  input  logic signed [31:0] in_c_z,
  output logic               out_valid,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic               out_skipped,
  output logic               out_degenerate
);
  import tfn_pkg::*;

  function automatic logic [3:0] lzc16(input logic [15:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 4'(15 - i);
    end
    return n;
  endfunction

  logic acc;
  logic [9:1] valid_r;
  tfn_flags_t fl_r [1:9];

  logic signed [32:0] e1_r [3], e2_r [3], e1_nxt [3], e2_nxt [3];
  logic signed [65:0] pa_r [3], pb_r [3];
  logic signed [66:0] cr3_r [3], cr4_r [3], cr5_r [3], cr6_r [3];
  logic [66:0]        mag_or_nxt, mag_or_r;
  logic [79:0]        or80;
  logic [4:0]         nz_r, nz_nxt;
  logic [3:0]         lz_r [5], lz_nxt [5];
  logic [6:0]         sh_r, sh_nxt;
  logic signed [31:0] cs_r [3];
  logic [31:0]        mag8_r [3], mag8_nxt [3];
  logic [2:0]         neg8_r, neg8_nxt;
  logic [63:0]        sq_r [3];
  logic [63:0]        sum_r;
  tfn_side_t          side9_r;

  logic               sq_valid, dv_valid;
  logic [31:0]        root;
  tfn_side_t          sq_side, dv_side;
  tfn_q_t [2:0]       dv_q;

  logic               out_valid_r;
  logic signed [15:0] nrm_r [3], nrm_nxt [3];
  tfn_flags_t         out_fl_r;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[8:1], acc};
    end
  end

  // Stage 1: edges from the first corner
  always_comb begin
    e1_nxt[0] = {in_b_x[31], in_b_x} - {in_a_x[31], in_a_x};
    e1_nxt[1] = {in_b_y[31], in_b_y} - {in_a_y[31], in_a_y};
    e1_nxt[2] = {in_b_z[31], in_b_z} - {in_a_z[31], in_a_z};
    e2_nxt[0] = {in_c_x[31], in_c_x} - {in_a_x[31], in_a_x};
    e2_nxt[1] = {in_c_y[31], in_c_y} - {in_a_y[31], in_a_y};
    e2_nxt[2] = {in_c_z[31], in_c_z} - {in_a_z[31], in_a_z};
  end

  always_ff @(posedge clk) begin
    fl_r[1].skip  <= (in_face_size != TRI_CORNERS);
    fl_r[1].degen <= 1'b0;
    e1_r <= e1_nxt;
    e2_r <= e2_nxt;
  end

  // Stage 2: six partial products
  always_ff @(posedge clk) begin
    fl_r[2] <= fl_r[1];
    pa_r[0] <= e1_r[1] * e2_r[2];
    pb_r[0] <= e1_r[2] * e2_r[1];
    pa_r[1] <= e1_r[2] * e2_r[0];
    pb_r[1] <= e1_r[0] * e2_r[2];
    pa_r[2] <= e1_r[0] * e2_r[1];
    pb_r[2] <= e1_r[1] * e2_r[0];
  end

  // Stage 3: exact cross product
  always_ff @(posedge clk) begin
    fl_r[3] <= fl_r[2];
    for (int i = 0; i < 3; i++) begin
      cr3_r[i] <= {pa_r[i][65], pa_r[i]} - {pb_r[i][65], pb_r[i]};
    end
  end

  // Stage 4: merge magnitudes so the largest bit length shows
  always_comb begin
    mag_or_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      mag_or_nxt = mag_or_nxt | (cr3_r[i][66] ? 67'(-cr3_r[i]) : 67'(cr3_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    fl_r[4]  <= fl_r[3];
    cr4_r    <= cr3_r;
    mag_or_r <= mag_or_nxt;
  end

  // Stage 5: per-chunk leading zero count, flag a zero cross product
  always_comb begin
    or80 = {mag_or_r, 13'b0};
    for (int i = 0; i < 5; i++) begin
      nz_nxt[i] = |or80[79-16*i -: 16];
      lz_nxt[i] = lzc16(or80[79-16*i -: 16]);
    end
  end

  // A skipped face is never reported as degenerate
  always_ff @(posedge clk) begin
    fl_r[5].skip  <= fl_r[4].skip;
    fl_r[5].degen <= !fl_r[4].skip && ~|mag_or_r;
    cr5_r <= cr4_r;
    nz_r  <= nz_nxt;
    lz_r  <= lz_nxt;
  end

  // Stage 6: pick the first nonzero chunk for the normalizing shift
  always_comb begin
    sh_nxt = 7'd0;
    for (int i = 4; i >= 0; i--) begin
      if (nz_r[i]) sh_nxt = 7'(i * 16) + 7'(lz_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    fl_r[6] <= fl_r[5];
    cr6_r   <= cr5_r;
    sh_r    <= sh_nxt;
  end

  // Stage 7: shift so the largest magnitude lands in [2^30, 2^31)
  always_ff @(posedge clk) begin
    logic [67:0] xs;
    fl_r[7] <= fl_r[6];
    for (int i = 0; i < 3; i++) begin
      xs = {cr6_r[i][66], cr6_r[i]} << sh_r;
      cs_r[i] <= xs[67:36];
    end
  end

  // Stage 8: magnitudes and squares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg8_nxt[i] = cs_r[i][31];
      mag8_nxt[i] = cs_r[i][31] ? 32'(-cs_r[i]) : 32'(cs_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    fl_r[8] <= fl_r[7];
    mag8_r  <= mag8_nxt;
    neg8_r  <= neg8_nxt;
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= {32'd0, mag8_nxt[i]} * {32'd0, mag8_nxt[i]};
    end
  end

  // Stage 9: sum of squares
  always_ff @(posedge clk) begin
    fl_r[9] <= fl_r[8];
    sum_r   <= sq_r[0] + sq_r[1] + sq_r[2];
    for (int i = 0; i < 3; i++) begin
      side9_r.mag[i] <= mag8_r[i];
    end
    side9_r.neg   <= neg8_r;
    side9_r.flags <= fl_r[8];
  end

  tfn_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (valid_r[9]),
    .in_sum    (sum_r),
    .in_side   (side9_r),
    .out_valid (sq_valid),
    .out_root  (root),
    .out_side  (sq_side)
  );

  tfn_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_root   (root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_side  (dv_side)
  );

  // Output stage: restore signs, zero the normal of skipped or flat faces
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_side.flags.skip || dv_side.flags.degen) begin
        nrm_nxt[i] = '0;
      end else if (dv_side.neg[i]) begin
        nrm_nxt[i] = -$signed({1'b0, dv_q[i]});
      end else begin
        nrm_nxt[i] = $signed({1'b0, dv_q[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    nrm_r    <= nrm_nxt;
    out_fl_r <= dv_side.flags;
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = nrm_r[0];
  assign out_normal_y   = nrm_r[1];
  assign out_normal_z   = nrm_r[2];
  assign out_skipped    = out_fl_r.skip;
  assign out_degenerate = out_fl_r.degen;

endmodule

// ----- hw/rtl/tfn_checker.sv -----
// Port-level checks for triangle_face_normal_core, attached by bind.
// Depends only on the core's ports.
module tfn_port_checks (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [15:0] out_normal_x,
  input logic signed [15:0] out_normal_y,
  input logic signed [15:0] out_normal_z,
  input logic               out_skipped,
  input logic               out_degenerate
);

  // Hold the result strobe low right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe high after reset");

  // Take every request: the pipeline never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("request held off by busy");

  // Never flag a face as both skipped and degenerate
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_skipped && out_degenerate))
    else $error("skipped and degenerate both set");

  // Drop the normal to zero for flagged faces
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_skipped || out_degenerate) |->
      out_normal_x == 16'sd0 && out_normal_y == 16'sd0 && out_normal_z == 16'sd0)
    else $error("flagged face with nonzero normal");

  // Keep unit components within one in Q2.14
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_normal_x >= -16'sd16384 && out_normal_x <= 16'sd16384 &&
      out_normal_y >= -16'sd16384 && out_normal_y <= 16'sd16384 &&
      out_normal_z >= -16'sd16384 && out_normal_z <= 16'sd16384)
    else $error("normal component out of range");

endmodule

bind triangle_face_normal_core tfn_port_checks u_tfn_port_checks (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_normal_x   (out_normal_x),
  .out_normal_y   (out_normal_y),
  .out_normal_z   (out_normal_z),
  .out_skipped    (out_skipped),
  .out_degenerate (out_degenerate)
);
